[src/bdq_pkg.sv]
// Package for the bounded deque shift store: sizes, operation and status codes,
// and the per-cell control struct. No dependencies.
package bdq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int POS_W  = 4;
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    // common width for comparing positions against the entry count
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_READ       = 3'd4,
        OP_WRITE      = 3'd5
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        logic load;        // take the operation's word
        logic shift_up;    // take the lower neighbor's entry
        logic shift_down;  // take the upper neighbor's entry
    } t_cell_ctl;

endpackage

[src/bdq_if.sv]
// Handshake channels of the bounded deque: operation items in, result items out.
// Depends on bdq_pkg.
interface bdq_op_if import bdq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;

    modport source (output valid, opcode, value, position, input ready);
    modport sink   (input valid, opcode, value, position, output ready);
endinterface

interface bdq_res_if import bdq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         entry_count;
    logic [ST_W-1:0]          status;

    modport source (output valid, read_value, entry_count, status, input ready);
    modport sink   (input valid, read_value, entry_count, status, output ready);
endinterface

[src/bdq_cell.sv]
// One storage cell of the deque chain: holds one entry and trades it with
// its neighbors on front push/pop. Depends on bdq_pkg.
module bdq_cell import bdq_pkg::*; (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_word,
    input  logic [DATA_W-1:0] i_lower,
    input  logic [DATA_W-1:0] i_upper,
    output logic [DATA_W-1:0] o_entry
);

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;

    always_comb begin
        priority if (i_ctl.load) begin
            n_entry = i_word;
        end else if (i_ctl.shift_up) begin
            n_entry = i_lower;
        end else if (i_ctl.shift_down) begin
            n_entry = i_upper;
        end else begin
            n_entry = r_entry;
        end
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

[src/bounded_deque_shift_store.sv]
// Top level of the bounded deque: a chain of entry cells, the count register
// and the result register. Depends on bdq_pkg, bdq_if and bdq_cell.
//
// Usage:
//   i_op  (sink)   : one operation per item - push back, push front, pop back,
//                    pop front, indexed read, indexed write (opcode, value,
//                    position). Opcodes six and seven do nothing.
//   o_res (source) : exactly one result item per operation - read_value (0
//                    unless an in-range read), entry_count after the
//                    operation, and status (ok, full, empty, out of range).
//   The result is registered, valid in the cycle after acceptance. Rate: one
//   item per cycle unless the receiver stalls. All cells load or shift in the
//   same edge, so a front push or pop moves the whole chain at once.
//   A stalled receiver holds the result register; i_op.ready drops only while
//   a result waits and the receiver is not taking it.
//   Reset (i_rst_n low, synchronous) empties the store and clears the output
//   valid. Entry contents are not cleared; only entries below the count are
//   ever read, and those were all written.
module bounded_deque_shift_store import bdq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bdq_op_if.sink    i_op,
    bdq_res_if.source o_res
);

    // count and result registers
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_value;
    logic [DATA_W-1:0] n_read_value;
    logic [CNT_W-1:0]  r_out_count;
    t_status           r_status;
    t_status           n_status;

    logic accept;
    logic full;
    logic empty;
    logic in_range;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;

    // chain wiring
    logic [DATA_W-1:0] w_entry [DEPTH];
    t_cell_ctl         w_ctl   [DEPTH];
    logic [DATA_W-1:0] rd_mux;

    // decoded operation (only meaningful with accept)
    logic do_add_back;
    logic do_add_front;
    logic do_drop_back;
    logic do_drop_front;
    logic do_read;
    logic do_write;

    // new item may enter whenever the result slot is free or draining
    assign i_op.ready = !r_out_valid || o_res.ready;
    assign accept     = i_op.valid && i_op.ready;

    assign full    = (r_count == CNT_W'(DEPTH));
    assign empty   = (r_count == '0);
    assign pos_ext = CMP_W'(i_op.position);
    assign cnt_ext = CMP_W'(r_count);
    // count never exceeds DEPTH, so this also keeps pos below DEPTH
    assign in_range = (pos_ext < cnt_ext);

    always_comb begin
        do_add_back   = 1'b0;
        do_add_front  = 1'b0;
        do_drop_back  = 1'b0;
        do_drop_front = 1'b0;
        do_read       = 1'b0;
        do_write      = 1'b0;
        unique case (i_op.opcode)
            OP_PUSH_BACK:  do_add_back   = 1'b1;
            OP_PUSH_FRONT: do_add_front  = 1'b1;
            OP_POP_BACK:   do_drop_back  = 1'b1;
            OP_POP_FRONT:  do_drop_front = 1'b1;
            OP_READ:       do_read       = 1'b1;
            OP_WRITE:      do_write      = 1'b1;
            default:       ;  // no-op codes
        endcase
    end

    // status and next count
    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        if (do_add_back || do_add_front) begin
            if (full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else if (do_drop_back || do_drop_front) begin
            if (empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_count = r_count - CNT_W'(1);
            end
        end else if (do_read || do_write) begin
            if (!in_range) begin
                n_status = ST_RANGE;
            end
        end
    end

    // read port: AND-OR select across the cell outputs
    always_comb begin
        rd_mux = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (pos_ext == CMP_W'(k)) begin
                rd_mux = rd_mux | w_entry[k];
            end
        end
    end

    assign n_read_value = (do_read && in_range) ? rd_mux : '0;

    // cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] lower;
        logic [DATA_W-1:0] upper;

        // back push lands at the slot just past the last entry;
        // indexed write lands at position
        assign w_ctl[g].load =
            accept && ((do_add_back && !full && (r_count == CNT_W'(g)))
                    || (do_write && in_range && (pos_ext == CMP_W'(g))));
        assign w_ctl[g].shift_up   = accept && do_add_front && !full;
        assign w_ctl[g].shift_down = accept && do_drop_front && !empty;

        if (g == 0) begin : g_first
            // the front cell takes the pushed word on a front push
            assign lower = i_op.value;
        end else begin : g_mid_lo
            assign lower = w_entry[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign upper = w_entry[g];
        end else begin : g_mid_hi
            assign upper = w_entry[g+1];
        end

        bdq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[g]),
            .i_word  (i_op.value),
            .i_lower (lower),
            .i_upper (upper),
            .o_entry (w_entry[g])
        );
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_value <= n_read_value;
            r_out_count  <= n_count;
            r_status     <= n_status;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.read_value  = r_read_value;
    assign o_res.entry_count = r_out_count;
    assign o_res.status      = r_status;

endmodule

[verif/bounded_deque_shift_store_tb.sv]
// Self-checking bench for bounded_deque_shift_store: a queue-fed driver and a
// clocked monitor that checks each result item against a shadow deque.
// Depends on bdq_pkg, bdq_if and the block's RTL.
`timescale 1ns / 1ps

module bounded_deque_shift_store_tb;
    import bdq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS  = 1100;
    localparam int HOLD_CYCLES = 150;
    localparam int SETTLE      = 4;
    // opcodes the block treats as no operation
    localparam logic [OP_W-1:0] OP_IDLE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_IDLE_B = 3'd7;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_deque_op;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]         entry_count;
        t_status                  status;
    } t_deque_answer;

    logic clk = 1'b0;
    logic rst_n;

    bdq_op_if  op_ch ();
    bdq_res_if res_ch ();

    bounded_deque_shift_store dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_op    (op_ch),
        .o_res   (res_ch)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // shadow deque and the answers still owed by the block
    logic signed [DATA_W-1:0] deque_words [DEPTH];
    int                       deque_len = 0;
    t_deque_answer            deque_answers [$];

    t_deque_op op_items [$];
    int        gen_len = 0;     // occupancy as seen by the generator
    int        ops_taken = 0;
    int        mismatches = 0;
    int        cycles = 0;
    logic      op_fire = 1'b0;  // item taken at the last rising edge
    logic      hold_off = 1'b0;

    // Applies one operation to the shadow deque and returns its result.
    function automatic t_deque_answer deque_step(t_deque_op op);
        t_deque_answer ans;
        int            k;
        ans.read_value = '0;
        ans.status     = ST_OK;
        case (op.opcode)
            OP_PUSH_BACK: begin
                if (deque_len >= DEPTH) begin
                    ans.status = ST_FULL;
                end else begin
                    deque_words[deque_len] = op.value;
                    deque_len++;
                end
            end
            OP_PUSH_FRONT: begin
                if (deque_len >= DEPTH) begin
                    ans.status = ST_FULL;
                end else begin
                    for (k = deque_len; k > 0; k--)
                        deque_words[k] = deque_words[k-1];
                    deque_words[0] = op.value;
                    deque_len++;
                end
            end
            OP_POP_BACK: begin
                if (deque_len == 0) ans.status = ST_EMPTY;
                else deque_len--;
            end
            OP_POP_FRONT: begin
                if (deque_len == 0) begin
                    ans.status = ST_EMPTY;
                end else begin
                    for (k = 0; k + 1 < deque_len; k++)
                        deque_words[k] = deque_words[k+1];
                    deque_len--;
                end
            end
            OP_READ: begin
                if (int'(op.position) < deque_len) ans.read_value = deque_words[op.position];
                else ans.status = ST_RANGE;
            end
            OP_WRITE: begin
                if (int'(op.position) < deque_len) deque_words[op.position] = op.value;
                else ans.status = ST_RANGE;
            end
            default: ;
        endcase
        ans.entry_count = CNT_W'(deque_len);
        return ans;
    endfunction

    // Queues one operation; the generator tracks occupancy to aim positions.
    task automatic add_op(input logic [OP_W-1:0] code, input logic signed [DATA_W-1:0] word,
                          input logic [POS_W-1:0] pos);
        t_deque_op it;
        it.opcode   = code;
        it.value    = word;
        it.position = pos;
        op_items.insert(op_items.size(), it);
        case (code)
            OP_PUSH_BACK, OP_PUSH_FRONT: if (gen_len < DEPTH) gen_len++;
            OP_POP_BACK, OP_POP_FRONT:   if (gen_len > 0) gen_len--;
            default: ;
        endcase
    endtask

    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly no gap, sometimes short, rarely long; none in a calm stretch.
    function automatic int pick_gap(input logic calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Sender: new items go out at the falling edge, held until taken.
    int   send_gap = 0;
    logic send_calm = 1'b0;
    always @(negedge clk) begin
        t_deque_op nxt;
        if (!rst_n) begin
            op_ch.valid <= 1'b0;
        end else if (op_ch.valid && !op_fire) begin
            // still waiting for the block to take it
        end else if (send_gap > 0) begin
            op_ch.valid <= 1'b0;
            send_gap--;
        end else if (op_items.size() > 0) begin
            nxt = op_items[0];
            op_items.delete(0);
            op_ch.valid    <= 1'b1;
            op_ch.opcode   <= nxt.opcode;
            op_ch.value    <= nxt.value;
            op_ch.position <= nxt.position;
            if ($urandom_range(0, 59) == 0) send_calm = !send_calm;
            send_gap = pick_gap(send_calm);
        end else begin
            op_ch.valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus the long hold-off below.
    int   recv_stall = 0;
    logic recv_calm = 1'b0;
    always @(negedge clk) begin
        if (!rst_n || hold_off) begin
            res_ch.ready <= 1'b0;
        end else if (recv_stall > 0) begin
            res_ch.ready <= 1'b0;
            recv_stall--;
        end else begin
            res_ch.ready <= 1'b1;
            if ($urandom_range(0, 59) == 0) recv_calm = !recv_calm;
            recv_stall = pick_gap(recv_calm);
        end
    end

    // One long receiver stall while the sender keeps offering: the result
    // register fills and the block must drop its input ready.
    initial begin
        wait (ops_taken >= 400);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Monitor: results are checked before the op taken at the same edge is
    // modeled, so a stray result cannot match its own operation.
    always @(posedge clk) begin
        t_deque_answer want;
        t_deque_op     taken;
        op_fire <= rst_n && op_ch.valid && op_ch.ready;
        if (rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (deque_answers.size() == 0) begin
                    $error("result item with none outstanding: read_value %0d count %0d status %0d",
                           res_ch.read_value, res_ch.entry_count, res_ch.status);
                    mismatches++;
                end else begin
                    want = deque_answers[0];
                    deque_answers.delete(0);
                    if (res_ch.read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d", want.read_value,
                               res_ch.read_value);
                        mismatches++;
                    end
                    if (res_ch.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d", want.entry_count,
                               res_ch.entry_count);
                        mismatches++;
                    end
                    if (res_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, res_ch.status);
                        mismatches++;
                    end
                end
            end
            if (op_ch.valid && op_ch.ready) begin
                taken.opcode   = op_ch.opcode;
                taken.value    = op_ch.value;
                taken.position = op_ch.position;
                deque_answers.insert(deque_answers.size(), deque_step(taken));
                ops_taken++;
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("bounded_deque_shift_store_tb: FAIL");
            $finish;
        end
    end

    t_opcode op_order [6] = '{OP_PUSH_BACK, OP_PUSH_FRONT, OP_POP_BACK, OP_POP_FRONT,
                              OP_READ, OP_WRITE};
    // cumulative odds per operation for fill, drain and mixed stretches
    int unsigned op_cuts [3][6] = '{'{35, 65, 72, 79, 88, 97},
                                   '{7, 14, 42, 70, 83, 96},
                                   '{15, 30, 42, 54, 75, 96}};

    initial begin
        int               n;
        int               j;
        int               tilt;
        int unsigned      r;
        logic [OP_W-1:0]  code;
        logic [POS_W-1:0] pos;

        rst_n          = 1'b0;
        op_ch.valid    = 1'b0;
        op_ch.opcode   = '0;
        op_ch.value    = '0;
        op_ch.position = '0;
        res_ch.ready   = 1'b0;

        // directed: empty-store corner cases and the idle opcodes
        add_op(OP_POP_BACK, '0, '0);
        add_op(OP_POP_FRONT, '0, '0);
        add_op(OP_READ, '0, '0);
        add_op(OP_WRITE, WORD_MAX, '0);
        add_op(OP_IDLE_A, WORD_MIN, 4'd15);
        add_op(OP_IDLE_B, WORD_MAX, 4'd9);
        // fill to capacity from both ends, mostly with extreme words
        for (j = 0; j < DEPTH; j++)
            add_op(j[0] ? OP_PUSH_FRONT : OP_PUSH_BACK,
                   (j % 4 == 0) ? WORD_MAX : (j % 4 == 1) ? WORD_MIN :
                   (j % 4 == 2) ? '1 : DATA_W'(j), '0);
        add_op(OP_PUSH_BACK, 32'sh1234_5678, '0);
        add_op(OP_PUSH_FRONT, 32'sh0bad_cafe, '0);
        add_op(OP_WRITE, WORD_MIN, 4'd15);
        add_op(OP_READ, '0, 4'd15);
        add_op(OP_POP_FRONT, '0, '0);
        add_op(OP_READ, '0, 4'd15);

        // random: stretches that lean toward filling, draining or neither
        tilt = 0;
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % 40 == 0) tilt = $urandom_range(0, 2);
            r = $urandom_range(0, 99);
            code = $urandom_range(0, 1) ? OP_IDLE_A : OP_IDLE_B;
            for (j = 5; j >= 0; j--)
                if (r < op_cuts[tilt][j]) code = op_order[j];
            if (gen_len > 0 && $urandom_range(0, 3) != 0)
                pos = POS_W'($urandom_range(0, gen_len - 1));
            else
                pos = POS_W'($urandom_range(0, 15));
            add_op(code, pick_word(), pos);
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (op_items.size() != 0 || op_ch.valid) @(posedge clk);
        while (deque_answers.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (mismatches == 0) begin
            $display("bounded_deque_shift_store_tb: PASS");
        end else begin
            $display("bounded_deque_shift_store_tb: FAIL");
        end
        $finish;
    end

endmodule
